// ===== sv/ubcp_pkg.sv =====
// Shared types and constants for the UART bootloader command parser.
// No dependencies.
`default_nettype none
package ubcp_pkg;
	localparam logic [7:0] C_INIT  = 8'h7F;
	localparam logic [7:0] C_GET   = 8'h00;
	localparam logic [7:0] C_VER   = 8'h01;
	localparam logic [7:0] C_ID    = 8'h02;
	localparam logic [7:0] C_READ  = 8'h11;
	localparam logic [7:0] C_GO    = 8'h21;
	localparam logic [7:0] C_WRITE = 8'h31;
	localparam logic [7:0] C_ERASE = 8'h43;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_TIMEOUT = 2'd1;
	localparam logic [1:0] OP_FLASH   = 2'd2;
	localparam logic [1:0] OP_SPARE   = 2'd3;

	localparam logic [2:0] K_TX     = 3'd0;
	localparam logic [2:0] K_READ   = 3'd1;
	localparam logic [2:0] K_STAGE  = 3'd2;
	localparam logic [2:0] K_COMMIT = 3'd3;
	localparam logic [2:0] K_ERASE  = 3'd4;
	localparam logic [2:0] K_JUMP   = 3'd5;

	localparam int REG_VERSION = 0;
	localparam int REG_DEVID   = 1;
	localparam int REG_FIRST   = 2;
	localparam int REG_PAGES   = 3;
	localparam int REG_ACK     = 4;
	localparam int REG_NACK    = 5;

	typedef enum logic [10:0] {
		P_IDLE    = 11'b00000000001,
		P_CHECK   = 11'b00000000010,
		P_ADDR    = 11'b00000000100,
		P_RLEN    = 11'b00000001000,
		P_RLENCHK = 11'b00000010000,
		P_RDATA   = 11'b00000100000,
		P_WLEN    = 11'b00001000000,
		P_WDATA   = 11'b00010000000,
		P_WCHK    = 11'b00100000000,
		P_ERASE1  = 11'b01000000000,
		P_ERASE2  = 11'b10000000000
	} phase_t;

	// Reply kinds the back end expands into result words.
	typedef enum logic [10:0] {
		R_BYTE   = 11'b00000000001,
		R_GET    = 11'b00000000010,
		R_VER    = 11'b00000000100,
		R_ID     = 11'b00000001000,
		R_ACKGO  = 11'b00000010000,
		R_ACKRD  = 11'b00000100000,
		R_STAGE  = 11'b00001000000,
		R_COMMIT = 11'b00010000000,
		R_ERASE  = 11'b00100000000,
		R_ACK    = 11'b01000000000,
		R_NACK   = 11'b10000000000
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  data;
		logic [15:0] addr;
		logic [10:0] cnt;
	} job_t;
endpackage
`default_nettype wire

// ===== sv/ubcp_front.sv =====
// Front end: accepts input words, runs the protocol state machine, queues jobs.
// Depends on ubcp_pkg.
`default_nettype none
module ubcp_front #(
	parameter int MAX_CHUNK = 256,
	parameter int ADDR_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     op,
	input  wire logic [7:0]     in_byte,
	input  wire logic [10:0]    first_erase_page,
	input  wire logic [10:0]    flash_page_count,
	output logic                job_valid,
	input  wire logic           job_stall,
	output ubcp_pkg::job_t      job
);
	localparam int AB = (ADDR_BITS >= 16) ? 16 : ADDR_BITS;
	localparam logic [15:0] AMASK = (AB >= 16) ? 16'hFFFF : 16'((32'd1 << AB) - 32'd1);
	localparam logic [9:0] CHUNK = 10'(MAX_CHUNK);

	ubcp_pkg::phase_t phase_q;
	logic [7:0]  cmd_q, xor_q, len_q;
	logic [15:0] addr_q;
	logic [2:0]  fc_q;
	logic [8:0]  bc_q;

	logic        jv_q;
	ubcp_pkg::job_t jb_q;

	logic        emit;
	ubcp_pkg::job_t nj;
	ubcp_pkg::phase_t nphase;
	logic [8:0]  bc_inc;
	logic        acc;

	assign in_stall  = jv_q && job_stall;
	assign acc       = in_valid && !in_stall;
	assign job_valid = jv_q;
	assign job       = jb_q;
	assign bc_inc    = bc_q + 9'd1;

	always_comb begin
		emit   = 1'b0;
		nj     = '{kind: ubcp_pkg::R_NACK, data: in_byte, addr: 16'd0, cnt: 11'd0};
		nphase = phase_q;
		if (phase_q == ubcp_pkg::P_RDATA) begin
			if (op == ubcp_pkg::OP_FLASH) begin
				emit = 1'b1;
				nj.kind = ubcp_pkg::R_BYTE;
				if (bc_inc > {1'b0, len_q}) nphase = ubcp_pkg::P_IDLE;
			end
		end else if (op[1]) begin
		end else if (phase_q == ubcp_pkg::P_IDLE) begin
			if (op == ubcp_pkg::OP_BYTE) begin
				if (in_byte == ubcp_pkg::C_INIT) begin
					emit = 1'b1;
					nj.kind = ubcp_pkg::R_ACK;
				end else nphase = ubcp_pkg::P_CHECK;
			end
		end else if (op == ubcp_pkg::OP_TIMEOUT) begin
			emit = 1'b1;
			nphase = ubcp_pkg::P_IDLE;
		end else begin
			case (phase_q)
				ubcp_pkg::P_CHECK: begin
					emit = 1'b1;
					nphase = ubcp_pkg::P_IDLE;
					if (in_byte == ~cmd_q) begin
						case (cmd_q)
							ubcp_pkg::C_GET: nj.kind = ubcp_pkg::R_GET;
							ubcp_pkg::C_VER: nj.kind = ubcp_pkg::R_VER;
							ubcp_pkg::C_ID:  nj.kind = ubcp_pkg::R_ID;
							ubcp_pkg::C_READ, ubcp_pkg::C_GO, ubcp_pkg::C_WRITE: begin
								nj.kind = ubcp_pkg::R_ACK;
								nphase = ubcp_pkg::P_ADDR;
							end
							ubcp_pkg::C_ERASE: begin
								nj.kind = ubcp_pkg::R_ACK;
								nphase = ubcp_pkg::P_ERASE1;
							end
							default: nj.kind = ubcp_pkg::R_NACK;
						endcase
					end
				end
				ubcp_pkg::P_ADDR: begin
					if (fc_q[2]) begin
						emit = 1'b1;
						nphase = ubcp_pkg::P_IDLE;
						if (in_byte == xor_q) begin
							nj.addr = addr_q & AMASK;
							if (cmd_q == ubcp_pkg::C_READ) begin
								nj.kind = ubcp_pkg::R_ACK;
								nphase = ubcp_pkg::P_RLEN;
							end else if (cmd_q == ubcp_pkg::C_WRITE) begin
								nj.kind = ubcp_pkg::R_ACK;
								nphase = ubcp_pkg::P_WLEN;
							end else nj.kind = ubcp_pkg::R_ACKGO;
						end
					end
				end
				ubcp_pkg::P_RLEN: nphase = ubcp_pkg::P_RLENCHK;
				ubcp_pkg::P_RLENCHK: begin
					emit = 1'b1;
					nphase = ubcp_pkg::P_IDLE;
					if (in_byte == ~len_q && ({2'b0, len_q} + 10'd1) <= CHUNK) begin
						nj.kind = ubcp_pkg::R_ACKRD;
						nj.addr = addr_q;
						nj.cnt  = {3'b0, len_q} + 11'd1;
						nphase  = ubcp_pkg::P_RDATA;
					end
				end
				ubcp_pkg::P_WLEN: begin
					if (({2'b0, in_byte} + 10'd1) > CHUNK) begin
						emit = 1'b1;
						nphase = ubcp_pkg::P_IDLE;
					end else nphase = ubcp_pkg::P_WDATA;
				end
				ubcp_pkg::P_WDATA: begin
					emit = 1'b1;
					nj.kind = ubcp_pkg::R_STAGE;
					nj.addr = {7'b0, bc_q};
					if (bc_inc > {1'b0, len_q}) nphase = ubcp_pkg::P_WCHK;
				end
				ubcp_pkg::P_WCHK: begin
					emit = 1'b1;
					nphase = ubcp_pkg::P_IDLE;
					if (in_byte == xor_q) begin
						nj.kind = ubcp_pkg::R_COMMIT;
						nj.addr = addr_q;
						nj.cnt  = {3'b0, len_q} + 11'd1;
					end
				end
				ubcp_pkg::P_ERASE1: begin
					if (in_byte == 8'hFF) nphase = ubcp_pkg::P_ERASE2;
					else begin
						emit = 1'b1;
						nphase = ubcp_pkg::P_IDLE;
					end
				end
				ubcp_pkg::P_ERASE2: begin
					emit = 1'b1;
					nphase = ubcp_pkg::P_IDLE;
					if (in_byte == 8'h00) begin
						nj.kind = ubcp_pkg::R_ERASE;
						nj.addr = {5'b0, first_erase_page};
						nj.cnt  = (flash_page_count > first_erase_page) ?
							flash_page_count - first_erase_page : 11'd0;
					end
				end
				default: nphase = ubcp_pkg::P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ubcp_pkg::P_IDLE;
			cmd_q <= '0; xor_q <= '0; len_q <= '0; addr_q <= '0;
			fc_q <= '0; bc_q <= '0; jv_q <= 1'b0;
			jb_q <= '{kind: ubcp_pkg::R_NACK, data: '0, addr: '0, cnt: '0};
		end else begin
			jv_q <= (acc && emit) || (jv_q && job_stall);
			if (acc) begin
				phase_q <= nphase;
				if (emit) jb_q <= nj;
				if (phase_q == ubcp_pkg::P_RDATA) begin
					if (op == ubcp_pkg::OP_FLASH) bc_q <= bc_inc;
				end else if (!op[1] && op == ubcp_pkg::OP_BYTE) begin
					case (phase_q)
						ubcp_pkg::P_IDLE: if (in_byte != ubcp_pkg::C_INIT) cmd_q <= in_byte;
						ubcp_pkg::P_CHECK: begin
							fc_q <= '0; xor_q <= '0; addr_q <= '0;
						end
						ubcp_pkg::P_ADDR: begin
							if (!fc_q[2]) begin
								xor_q <= xor_q ^ in_byte;
								if (fc_q[1]) addr_q <= {addr_q[7:0], in_byte};
								fc_q <= fc_q + 3'd1;
							end else if (in_byte == xor_q) addr_q <= addr_q & AMASK;
						end
						ubcp_pkg::P_RLEN: len_q <= in_byte;
						ubcp_pkg::P_RLENCHK: bc_q <= '0;
						ubcp_pkg::P_WLEN: if (nphase == ubcp_pkg::P_WDATA) begin
							len_q <= in_byte; xor_q <= in_byte; bc_q <= '0;
						end
						ubcp_pkg::P_WDATA: begin
							xor_q <= xor_q ^ in_byte;
							bc_q <= bc_inc;
						end
						default: ;
					endcase
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		jv_q && job_stall |=> jv_q && $stable(jb_q)) else $error("job dropped");
	a_fc: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= 3'd4) else $error("field counter overrun");
	a_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ubcp_pkg::P_RDATA |-> {1'b0, len_q} >= bc_q) else $error("read overrun");
endmodule
`default_nettype wire

// ===== sv/ubcp_back.sv =====
// Back end: expands queued jobs into result words through an output register.
// Depends on ubcp_pkg.
`default_nettype none
module ubcp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_stall,
	input  ubcp_pkg::job_t      job,
	input  wire logic [7:0]     version_byte,
	input  wire logic [15:0]    device_id,
	input  wire logic [7:0]     ack_byte,
	input  wire logic [7:0]     nack_byte,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [2:0]          kind,
	output logic [7:0]          out_byte,
	output logic [15:0]         address,
	output logic [10:0]         count,
	output logic                last
);
	logic        busy_q;
	ubcp_pkg::job_t cur_q;
	logic [3:0]  idx_q;
	logic        ov_q;
	logic [2:0]  k_q;
	logic [7:0]  b_q;
	logic [15:0] a_q;
	logic [10:0] c_q;
	logic        l_q;

	logic [2:0]  wk;
	logic [7:0]  wb;
	logic [15:0] wa;
	logic [10:0] wc;
	logic        wl;
	logic        take, adv;

	assign adv       = busy_q && (!ov_q || !out_stall);
	assign job_stall = busy_q;
	assign take      = job_valid && !busy_q;
	assign out_valid = ov_q;
	assign kind = k_q; assign out_byte = b_q; assign address = a_q;
	assign count = c_q; assign last = l_q;

	always_comb begin
		wk = ubcp_pkg::K_TX; wb = ack_byte; wa = '0; wc = '0; wl = 1'b1;
		case (cur_q.kind)
			ubcp_pkg::R_BYTE: wb = cur_q.data;
			ubcp_pkg::R_ACK: wb = ack_byte;
			ubcp_pkg::R_NACK: wb = nack_byte;
			ubcp_pkg::R_GET: begin
				wl = (idx_q == 4'd10);
				case (idx_q)
					4'd1: wb = 8'd7;
					4'd2: wb = version_byte;
					4'd3: wb = ubcp_pkg::C_GET;
					4'd4: wb = ubcp_pkg::C_VER;
					4'd5: wb = ubcp_pkg::C_ID;
					4'd6: wb = ubcp_pkg::C_READ;
					4'd7: wb = ubcp_pkg::C_GO;
					4'd8: wb = ubcp_pkg::C_WRITE;
					4'd9: wb = ubcp_pkg::C_ERASE;
					default: wb = ack_byte;
				endcase
			end
			ubcp_pkg::R_VER: begin
				wl = (idx_q == 4'd4);
				case (idx_q)
					4'd1: wb = version_byte;
					4'd2, 4'd3: wb = 8'd0;
					default: wb = ack_byte;
				endcase
			end
			ubcp_pkg::R_ID: begin
				wl = (idx_q == 4'd4);
				case (idx_q)
					4'd1: wb = 8'd1;
					4'd2: wb = device_id[15:8];
					4'd3: wb = device_id[7:0];
					default: wb = ack_byte;
				endcase
			end
			ubcp_pkg::R_ACKGO, ubcp_pkg::R_ACKRD: begin
				wl = (idx_q == 4'd1);
				if (idx_q == 4'd1) begin
					wk = (cur_q.kind == ubcp_pkg::R_ACKGO) ? ubcp_pkg::K_JUMP : ubcp_pkg::K_READ;
					wb = '0; wa = cur_q.addr; wc = cur_q.cnt;
				end
			end
			ubcp_pkg::R_STAGE: begin
				wk = ubcp_pkg::K_STAGE; wb = cur_q.data; wa = cur_q.addr;
			end
			ubcp_pkg::R_COMMIT, ubcp_pkg::R_ERASE: begin
				wl = (idx_q == 4'd1);
				if (idx_q == 4'd0) begin
					wk = (cur_q.kind == ubcp_pkg::R_COMMIT) ? ubcp_pkg::K_COMMIT : ubcp_pkg::K_ERASE;
					wb = '0; wa = cur_q.addr; wc = cur_q.cnt;
				end
			end
			default: wb = nack_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; ov_q <= 1'b0; idx_q <= '0;
			cur_q <= '{kind: ubcp_pkg::R_NACK, data: '0, addr: '0, cnt: '0};
			k_q <= ubcp_pkg::K_TX; b_q <= '0; a_q <= '0; c_q <= '0; l_q <= 1'b0;
		end else begin
			ov_q <= adv || (ov_q && out_stall);
			if (take) begin
				busy_q <= 1'b1; cur_q <= job; idx_q <= '0;
			end else if (adv) begin
				k_q <= wk; b_q <= wb; a_q <= wa; c_q <= wc; l_q <= wl;
				idx_q <= idx_q + 4'd1;
				if (wl) busy_q <= 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(b_q) && $stable(l_q)) else $error("word lost");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 4'd11) else $error("index overrun");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q && idx_q == 4'd0) else $error("job not loaded");
endmodule
`default_nettype wire

// ===== sv/uart_bootloader_command_parser.sv =====
// Top level of the UART bootloader command parser.
// Depends on ubcp_pkg, ubcp_front and ubcp_back.
// The front state machine takes each input word and parks at most one job in a register
// toward the back end. The back end loads a job from that register only once it has
// emitted the last word of the previous job, and then, while the output is not stalled,
// emits its result words one per cycle through an output register. A job expands into
// one to eleven result words, eleven for a get command. The input stalls only while the
// job register holds a job the back end has not yet loaded; output stalls hold the back
// end in place.
`default_nettype none
module uart_bootloader_command_parser #(
	parameter int MAX_CHUNK = 256,
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [7:0]       out_byte,
	output logic [15:0]      address,
	output logic [10:0]      count,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	logic [7:0]  ver_q, ack_q, nack_q;
	logic [15:0] id_q;
	logic [10:0] first_q, pages_q;
	logic        jv, js;
	ubcp_pkg::job_t jb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= 8'd16; id_q <= '0; first_q <= '0; pages_q <= '0;
			ack_q <= 8'd121; nack_q <= 8'd31;
		end else if (cfg_we) begin
			case (int'(cfg_index))
				ubcp_pkg::REG_VERSION: ver_q <= cfg_data[7:0];
				ubcp_pkg::REG_DEVID:   id_q <= cfg_data;
				ubcp_pkg::REG_FIRST:   first_q <= cfg_data[10:0];
				ubcp_pkg::REG_PAGES:   pages_q <= cfg_data[10:0];
				ubcp_pkg::REG_ACK:     ack_q <= cfg_data[7:0];
				ubcp_pkg::REG_NACK:    nack_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ubcp_front #(.MAX_CHUNK(MAX_CHUNK), .ADDR_BITS(ADDR_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .in_byte,
		.first_erase_page(first_q), .flash_page_count(pages_q),
		.job_valid(jv), .job_stall(js), .job(jb)
	);

	ubcp_back u_back (
		.clk, .arst_n, .job_valid(jv), .job_stall(js), .job(jb),
		.version_byte(ver_q), .device_id(id_q), .ack_byte(ack_q), .nack_byte(nack_q),
		.out_valid, .out_stall, .kind, .out_byte, .address, .count, .last
	);
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the UART bootloader command parser: directed and random protocol traffic,
// results checked word by word against an in-bench predictor through a scoreboard class.
// Depends on ubcp_pkg and uart_bootloader_command_parser.
`default_nettype none
module testbench;
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [15:0] addr;
		logic [10:0] cnt;
		logic        last;
	} word_t;

	typedef enum int {
		S_IDLE, S_CHECK, S_ADDR, S_RLEN, S_RLENCHK, S_RDATA,
		S_WLEN, S_WDATA, S_WCHK, S_ERASE1, S_ERASE2
	} parse_t;

	class parser_scoreboard;
		logic [7:0]  version, ack, nack;
		logic [15:0] devid;
		logic [10:0] first_page, pages;
		parse_t      phase;
		logic [7:0]  cmd, xsum, len_m1;
		logic [15:0] addr;
		logic [2:0]  field;
		logic [8:0]  bcnt;
		word_t       pending[$];
		word_t       batch[$];
		int          errors;

		function new();
			version = 8'd16; devid = 0; first_page = 0; pages = 0;
			ack = 8'd121; nack = 8'd31;
			phase = S_IDLE; cmd = 0; xsum = 0; len_m1 = 0; addr = 0; field = 0; bcnt = 0;
			errors = 0;
		endfunction

		function void set_reg(int idx, logic [15:0] v);
			case (idx)
				ubcp_pkg::REG_VERSION: version = v[7:0];
				ubcp_pkg::REG_DEVID:   devid = v;
				ubcp_pkg::REG_FIRST:   first_page = v[10:0];
				ubcp_pkg::REG_PAGES:   pages = v[10:0];
				ubcp_pkg::REG_ACK:     ack = v[7:0];
				ubcp_pkg::REG_NACK:    nack = v[7:0];
				default: ;
			endcase
		endfunction

		function void put(logic [2:0] k, logic [7:0] d, logic [15:0] a, logic [10:0] c);
			word_t w;
			w.kind = k; w.data = d; w.addr = a; w.cnt = c; w.last = 1'b0;
			batch.push_back(w);
		endfunction

		function void tx(logic [7:0] b);
			put(ubcp_pkg::K_TX, b, 16'd0, 11'd0);
		endfunction

		function void fail_idle();
			tx(nack);
			phase = S_IDLE;
		endfunction

		function void note_word(logic [1:0] op, logic [7:0] b);
			batch.delete();
			if (phase == S_RDATA) begin
				if (op == ubcp_pkg::OP_FLASH) begin
					tx(b);
					bcnt = bcnt + 9'd1;
					if (bcnt > {1'b0, len_m1}) phase = S_IDLE;
				end
			end else if (op >= ubcp_pkg::OP_FLASH) begin
			end else if (phase == S_IDLE) begin
				if (op == ubcp_pkg::OP_BYTE) begin
					if (b == ubcp_pkg::C_INIT) tx(ack);
					else begin
						cmd = b;
						phase = S_CHECK;
					end
				end
			end else if (op == ubcp_pkg::OP_TIMEOUT) begin
				fail_idle();
			end else begin
				case (phase)
					S_CHECK: begin
						if (b != ~cmd) fail_idle();
						else case (cmd)
							ubcp_pkg::C_GET: begin
								tx(ack); tx(8'd7); tx(version);
								tx(ubcp_pkg::C_GET); tx(ubcp_pkg::C_VER); tx(ubcp_pkg::C_ID);
								tx(ubcp_pkg::C_READ); tx(ubcp_pkg::C_GO);
								tx(ubcp_pkg::C_WRITE); tx(ubcp_pkg::C_ERASE); tx(ack);
								phase = S_IDLE;
							end
							ubcp_pkg::C_VER: begin
								tx(ack); tx(version); tx(8'd0); tx(8'd0); tx(ack);
								phase = S_IDLE;
							end
							ubcp_pkg::C_ID: begin
								tx(ack); tx(8'd1); tx(devid[15:8]); tx(devid[7:0]); tx(ack);
								phase = S_IDLE;
							end
							ubcp_pkg::C_READ, ubcp_pkg::C_GO, ubcp_pkg::C_WRITE: begin
								tx(ack);
								phase = S_ADDR; field = 0; xsum = 0; addr = 0;
							end
							ubcp_pkg::C_ERASE: begin
								tx(ack);
								phase = S_ERASE1;
							end
							default: fail_idle();
						endcase
					end
					S_ADDR: begin
						if (field < 3'd4) begin
							xsum ^= b;
							if (field >= 3'd2) addr = {addr[7:0], b};
							field++;
						end else if (b != xsum) fail_idle();
						else begin
							tx(ack);
							if (cmd == ubcp_pkg::C_READ) phase = S_RLEN;
							else if (cmd == ubcp_pkg::C_WRITE) phase = S_WLEN;
							else begin
								put(ubcp_pkg::K_JUMP, 8'd0, addr, 11'd0);
								phase = S_IDLE;
							end
						end
					end
					S_RLEN: begin
						len_m1 = b;
						phase = S_RLENCHK;
					end
					S_RLENCHK: begin
						if (b != ~len_m1) fail_idle();
						else begin
							tx(ack);
							put(ubcp_pkg::K_READ, 8'd0, addr, {3'd0, len_m1} + 11'd1);
							bcnt = 0;
							phase = S_RDATA;
						end
					end
					S_WLEN: begin
						len_m1 = b; xsum = b; bcnt = 0;
						phase = S_WDATA;
					end
					S_WDATA: begin
						put(ubcp_pkg::K_STAGE, b, {7'd0, bcnt}, 11'd0);
						xsum ^= b;
						bcnt = bcnt + 9'd1;
						if (bcnt > {1'b0, len_m1}) phase = S_WCHK;
					end
					S_WCHK: begin
						if (b == xsum) begin
							put(ubcp_pkg::K_COMMIT, 8'd0, addr, {3'd0, len_m1} + 11'd1);
							tx(ack);
							phase = S_IDLE;
						end else fail_idle();
					end
					S_ERASE1: begin
						if (b == 8'hFF) phase = S_ERASE2;
						else fail_idle();
					end
					S_ERASE2: begin
						if (b == 8'h00) begin
							put(ubcp_pkg::K_ERASE, 8'd0, {5'd0, first_page},
								(pages > first_page) ? pages - first_page : 11'd0);
							tx(ack);
							phase = S_IDLE;
						end else fail_idle();
					end
					default: phase = S_IDLE;
				endcase
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) pending.push_back(batch[i]);
		endfunction

		function void check_word(word_t got);
			word_t w;
			if (pending.size() == 0) begin
				$error("unexpected result word kind %0d", got.kind);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.kind !== w.kind) begin
				$error("kind expected %0d got %0d", w.kind, got.kind); errors++;
			end
			if (got.data !== w.data) begin
				$error("out_byte expected %0h got %0h", w.data, got.data); errors++;
			end
			if (got.addr !== w.addr) begin
				$error("address expected %0h got %0h", w.addr, got.addr); errors++;
			end
			if (got.cnt !== w.cnt) begin
				$error("count expected %0d got %0d", w.cnt, got.cnt); errors++;
			end
			if (got.last !== w.last) begin
				$error("last expected %0d got %0d", w.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_we = 0;
	logic [1:0] op = 0;
	logic [7:0] in_byte = 0;
	logic [2:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;
	logic in_stall, out_valid, last;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic [15:0] address;
	logic [10:0] count;

	parser_scoreboard sb = new();
	bit quiet = 0;
	bit hold_rx = 0;
	logic [1:0] wop[$];
	logic [7:0] wbyte[$];

	always #1 clk = ~clk;

	uart_bootloader_command_parser DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.in_byte(in_byte), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.out_byte(out_byte), .address(address), .count(count), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				for (n = 0; n < 300; n++) @(posedge clk);
				hold_rx = 0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 4);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_word({kind, out_byte, address, count, last});

	task automatic add(logic [1:0] o, logic [7:0] b);
		wop.push_back(o);
		wbyte.push_back(b);
	endtask

	task automatic send_all();
		int g;
		while (wop.size() > 0) begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				g = $urandom_range(1, 4);
				repeat (g) @(posedge clk);
			end
			in_valid <= 1'b1;
			op <= wop[0];
			in_byte <= wbyte[0];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.note_word(wop.pop_front(), wbyte.pop_front());
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic cmd(logic [7:0] c);
		add(ubcp_pkg::OP_BYTE, c);
		add(ubcp_pkg::OP_BYTE, ~c);
	endtask

	task automatic addr5(logic [31:0] a, bit bad);
		logic [7:0] x;
		x = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
		add(ubcp_pkg::OP_BYTE, a[31:24]); add(ubcp_pkg::OP_BYTE, a[23:16]);
		add(ubcp_pkg::OP_BYTE, a[15:8]); add(ubcp_pkg::OP_BYTE, a[7:0]);
		add(ubcp_pkg::OP_BYTE, bad ? ~x : x);
	endtask

	task automatic random_seq();
		int s, n, i;
		logic [7:0] x, b;
		s = $urandom_range(0, 11);
		case (s)
			0: add(ubcp_pkg::OP_BYTE, ubcp_pkg::C_INIT);
			1: cmd(ubcp_pkg::C_GET);
			2: cmd(ubcp_pkg::C_VER);
			3: cmd(ubcp_pkg::C_ID);
			4: begin
				cmd(ubcp_pkg::C_READ); addr5($urandom, $urandom_range(0, 9) == 0);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
				add(ubcp_pkg::OP_BYTE, n[7:0]);
				add(ubcp_pkg::OP_BYTE, ($urandom_range(0, 9) == 0) ? n[7:0] : ~n[7:0]);
				for (i = 0; i <= n; i++) begin
					if ($urandom_range(0, 9) == 0)
						add(2'($urandom_range(0, 1)), 8'($urandom));
					add(ubcp_pkg::OP_FLASH, 8'($urandom));
				end
			end
			5: begin cmd(ubcp_pkg::C_GO); addr5($urandom, $urandom_range(0, 9) == 0); end
			6: begin
				cmd(ubcp_pkg::C_WRITE); addr5($urandom, 0);
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
				add(ubcp_pkg::OP_BYTE, n[7:0]);
				x = n[7:0];
				for (i = 0; i <= n; i++) begin
					b = 8'($urandom); x ^= b; add(ubcp_pkg::OP_BYTE, b);
				end
				add(ubcp_pkg::OP_BYTE, ($urandom_range(0, 7) == 0) ? ~x : x);
			end
			7: begin
				cmd(ubcp_pkg::C_ERASE);
				add(ubcp_pkg::OP_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF);
				add(ubcp_pkg::OP_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
			end
			8: begin add(ubcp_pkg::OP_BYTE, 8'($urandom)); add(ubcp_pkg::OP_BYTE, 8'($urandom)); end
			9: begin
				add(ubcp_pkg::OP_BYTE, 8'($urandom)); add(ubcp_pkg::OP_TIMEOUT, 8'($urandom));
			end
			10: add(2'($urandom_range(1, 3)), 8'($urandom));
			default: begin
				cmd(ubcp_pkg::C_READ); add(ubcp_pkg::OP_BYTE, 8'($urandom));
				add(ubcp_pkg::OP_TIMEOUT, 8'h00);
			end
		endcase
	endtask

	initial begin
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		add(ubcp_pkg::OP_TIMEOUT, 8'hFF); add(ubcp_pkg::OP_FLASH, 8'hAA);
		add(ubcp_pkg::OP_SPARE, 8'h55);
		add(ubcp_pkg::OP_BYTE, ubcp_pkg::C_INIT);
		cmd(ubcp_pkg::C_GET); cmd(ubcp_pkg::C_VER); cmd(ubcp_pkg::C_ID);
		add(ubcp_pkg::OP_BYTE, 8'h55); add(ubcp_pkg::OP_BYTE, 8'h55);
		cmd(8'hFF);
		send_all(); drain();

		write_reg(ubcp_pkg::REG_VERSION, 16'hFF); write_reg(ubcp_pkg::REG_DEVID, 16'hFFFF);
		write_reg(ubcp_pkg::REG_FIRST, 16'd1024); write_reg(ubcp_pkg::REG_PAGES, 16'd0);
		write_reg(ubcp_pkg::REG_ACK, 16'hFF); write_reg(ubcp_pkg::REG_NACK, 16'h00);
		cmd(ubcp_pkg::C_ID); cmd(ubcp_pkg::C_ERASE);
		add(ubcp_pkg::OP_BYTE, 8'hFF); add(ubcp_pkg::OP_BYTE, 8'h00);
		cmd(ubcp_pkg::C_GO); addr5(32'hFFFF_FFFF, 0);
		send_all(); drain();

		write_reg(ubcp_pkg::REG_FIRST, 16'd4); write_reg(ubcp_pkg::REG_PAGES, 16'd1024);
		cmd(ubcp_pkg::C_READ); addr5(32'h1234_00FF, 0);
		add(ubcp_pkg::OP_BYTE, 8'd1); add(ubcp_pkg::OP_BYTE, 8'hFE);
		add(ubcp_pkg::OP_BYTE, 8'h00); add(ubcp_pkg::OP_TIMEOUT, 8'h00);
		add(ubcp_pkg::OP_FLASH, 8'h00); add(ubcp_pkg::OP_FLASH, 8'hFF);
		cmd(ubcp_pkg::C_ERASE); add(ubcp_pkg::OP_BYTE, 8'hFF); add(ubcp_pkg::OP_BYTE, 8'h00);
		send_all(); drain();

		// long receiver hold-off while a get reply backs up
		hold_rx = 1;
		for (i = 0; i < 6; i++) cmd(ubcp_pkg::C_GET);
		send_all(); drain();

		for (i = 0; i < 6; i++) begin
			write_reg(ubcp_pkg::REG_VERSION, 16'($urandom));
			write_reg(ubcp_pkg::REG_DEVID, 16'($urandom));
			write_reg(ubcp_pkg::REG_FIRST, 16'($urandom_range(0, 1024)));
			write_reg(ubcp_pkg::REG_PAGES, 16'($urandom_range(0, 1024)));
			write_reg(ubcp_pkg::REG_ACK, 16'($urandom));
			write_reg(ubcp_pkg::REG_NACK, 16'($urandom));
			while (wop.size() < 65) random_seq();
			if (i == 5) quiet = 1;
			send_all(); drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS uart_bootloader_command_parser");
		else
			$display("FAIL uart_bootloader_command_parser");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL uart_bootloader_command_parser");
		$finish;
	end
endmodule
`default_nettype wire
